/* rtl/core/cpfc_pkg.sv */
// ----------------------------------------------------------------------------
// cpfc_pkg
// shared types and constants for the column predicate filter and count core
// ----------------------------------------------------------------------------
package cpfc_pkg;

    localparam int unsigned ElemW  = 64;
    localparam int unsigned CountW = 17;
    localparam int unsigned IndexW = 2;
    localparam logic [CountW-1:0] MaxBatchRows = 17'd65536;

    typedef enum logic [2:0] {
        MODE_INT_EQ   = 3'd0,
        MODE_INT_GT   = 3'd1,
        MODE_INT_LT   = 3'd2,
        MODE_INT_GE   = 3'd3,
        MODE_INT_LE   = 3'd4,
        MODE_FLT_GT   = 3'd5,
        MODE_FLT_LT   = 3'd6,
        MODE_UNUSED   = 3'd7
    } mode_t;

    localparam logic [IndexW-1:0] REG_MODE     = 2'd0;
    localparam logic [IndexW-1:0] REG_VALUE    = 2'd1;
    localparam logic [IndexW-1:0] REG_VALIDITY = 2'd2;

    typedef struct packed {
        logic [ElemW-1:0] element_bits;
        logic             row_valid;
        logic             last_row;
    } in_word_t;

    typedef struct packed {
        logic              row_passes;
        logic [CountW-1:0] passing_count;
        logic              batch_end;
    } out_word_t;

    typedef struct packed {
        mode_t            mode;
        logic [ElemW-1:0] value;
        logic             use_validity;
    } cfg_t;

endpackage

/* rtl/core/cpfc_if.sv */
// ----------------------------------------------------------------------------
// cpfc_if
// valid/ready channel interfaces for the core
// ----------------------------------------------------------------------------
interface cpfc_in_if;
    logic                valid;
    logic                ready;
    cpfc_pkg::in_word_t  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface cpfc_out_if;
    logic                valid;
    logic                ready;
    cpfc_pkg::out_word_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface cpfc_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [cpfc_pkg::IndexW-1:0]   index;
    logic [cpfc_pkg::ElemW-1:0]    data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/core/column_predicate_filter_count_core.sv */
// ----------------------------------------------------------------------------
// column_predicate_filter_count_core
// column filter: compare each element, emit pass bit and running pass count
// ----------------------------------------------------------------------------
// usage
// - in channel: one word per row (element_bits, row_valid, last_row)
// - out channel: one word per row (row_passes, passing_count, batch_end)
// - cfg channel: index 0 compare_mode, 1 compare_value, 2 use_validity;
//   always ready, write only while no row is in flight
// - from input accept to output valid: input register, then result register
//   with the compare and count update between them
// - throughput: one row per cycle while the receiver keeps out.ready high
// - the input register is refilled when it is empty or the result register
//   frees up, so a stalled receiver holds both full stages and in.ready drops
// - the pass count saturates at 65536 and clears after a last row
// - reset clears configuration, the count and both valid flags
// ----------------------------------------------------------------------------
module column_predicate_filter_count_core
(
    input  logic              clk,
    input  logic              rst_n,
    cpfc_in_if.sink           in,
    cpfc_out_if.source        out,
    cpfc_cfg_if.sink          cfg
);

    cpfc_pkg::cfg_t                    cfg_reg;
    cpfc_pkg::in_word_t                in_data_reg;
    logic                              in_valid_reg;
    cpfc_pkg::out_word_t               out_data_reg;
    logic                              out_valid_reg;
    logic [cpfc_pkg::CountW-1:0]       count_reg, count_next;
    logic                              hit, pass, adv_out, adv_in;

    // configuration writes
    assign cfg.ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{mode: cpfc_pkg::MODE_INT_EQ, value: '0, use_validity: 1'b0};
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                cpfc_pkg::REG_MODE:     cfg_reg.mode <= cpfc_pkg::mode_t'(cfg.data[2:0]);
                cpfc_pkg::REG_VALUE:    cfg_reg.value <= cfg.data;
                cpfc_pkg::REG_VALIDITY: cfg_reg.use_validity <= cfg.data[0];
                default:                cfg_reg <= cfg_reg;
            endcase
        end
    end

    // handshake
    assign adv_out  = !out_valid_reg || out.ready;
    assign adv_in   = !in_valid_reg || adv_out;
    assign in.ready = adv_in;
    assign out.valid = out_valid_reg;
    assign out.data  = out_data_reg;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (adv_in)
        begin
            in_valid_reg <= in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_in && in.valid)
        begin
            in_data_reg <= in.data;
        end
    end

    cpfc_compare u_compare
    (
        .element_bits (in_data_reg.element_bits),
        .cfg          (cfg_reg),
        .hit          (hit)
    );

    // pass and saturating count
    assign pass = hit && (!cfg_reg.use_validity || in_data_reg.row_valid);
    assign count_next = (pass && count_reg < cpfc_pkg::MaxBatchRows)
                        ? count_reg + 1'b1 : count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else if (adv_out)
        begin
            out_valid_reg <= in_valid_reg;
            if (in_valid_reg)
            begin
                count_reg <= in_data_reg.last_row ? '0 : count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_out && in_valid_reg)
        begin
            out_data_reg <= '{row_passes: pass, passing_count: count_next,
                              batch_end: in_data_reg.last_row};
        end
    end

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= cpfc_pkg::MaxBatchRows)
        else $error("count above batch bound");
    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        adv_out && in_valid_reg && in_data_reg.last_row |=> count_reg == '0)
        else $error("count not cleared after last row");
    a_pass_counts: assert property (@(posedge clk) disable iff (!rst_n)
        adv_out && in_valid_reg && !pass |=>
        out_data_reg.passing_count == $past(count_reg))
        else $error("count moved on a failing row");
    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out.valid && !out.ready |=> out.valid && $stable(count_reg))
        else $error("state moved while stalled");
`endif

endmodule

/* rtl/core/cpfc_compare.sv */
// ----------------------------------------------------------------------------
// cpfc_compare
// predicate test of one element against the configured operand
// ----------------------------------------------------------------------------
module cpfc_compare
(
    input  logic [cpfc_pkg::ElemW-1:0] element_bits,
    input  cpfc_pkg::cfg_t             cfg,
    output logic                       hit
);

    localparam int unsigned W = cpfc_pkg::ElemW;

    logic [W-1:0] ek_int, ck_int, ek_flt, ck_flt, e_z, c_z;
    logic         e_nan, c_nan;

    // order-preserving unsigned keys
    assign ek_int = {~element_bits[W-1], element_bits[W-2:0]};
    assign ck_int = {~cfg.value[W-1], cfg.value[W-2:0]};

    // fold -0 onto +0
    assign e_z = (element_bits[W-2:0] == '0) ? '0 : element_bits;
    assign c_z = (cfg.value[W-2:0] == '0) ? '0 : cfg.value;
    assign ek_flt = e_z[W-1] ? ~e_z : {1'b1, e_z[W-2:0]};
    assign ck_flt = c_z[W-1] ? ~c_z : {1'b1, c_z[W-2:0]};

    assign e_nan = (element_bits[62:52] == 11'h7FF) && (element_bits[51:0] != '0);
    assign c_nan = (cfg.value[62:52] == 11'h7FF) && (cfg.value[51:0] != '0);

    // mode select
    always_comb
    begin
        unique case (cfg.mode)
            cpfc_pkg::MODE_INT_EQ: hit = element_bits == cfg.value;
            cpfc_pkg::MODE_INT_GT: hit = ek_int > ck_int;
            cpfc_pkg::MODE_INT_LT: hit = ek_int < ck_int;
            cpfc_pkg::MODE_INT_GE: hit = ek_int >= ck_int;
            cpfc_pkg::MODE_INT_LE: hit = ek_int <= ck_int;
            cpfc_pkg::MODE_FLT_GT: hit = !e_nan && !c_nan && (ek_flt > ck_flt);
            cpfc_pkg::MODE_FLT_LT: hit = !e_nan && !c_nan && (ek_flt < ck_flt);
            default:               hit = 1'b0;
        endcase
    end

endmodule
